@@ design/vcrp_pkg.sv @@
// Package for the video chip register port.
// Holds the register numbers, access codes, address constants and the
// structs shared by the port's modules. Depends on nothing.
package vcrp_pkg;

    // Access codes.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register numbers of the eight-register window.
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    localparam int SPRITE_BYTES    = 256;
    localparam int PALETTE_ENTRIES = 32;
    localparam int SPR_AW          = $clog2(SPRITE_BYTES);
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

    localparam logic [14:0] PALETTE_BASE = 15'h3F00;

    // One bus access as it sits in the input register.
    typedef struct packed {
        logic       opcode;
        logic [2:0] reg_sel;
        logic [7:0] wdata;
        logic       vblank_flag;
        logic       sprite_zero_hit;
        logic       sprite_overflow;
        logic [7:0] buffered_read;
    } t_item;

    // One result word.
    typedef struct packed {
        logic [7:0]  read_data;
        logic        vram_write_en;
        logic [14:0] vram_write_addr;
        logic [7:0]  vram_write_byte;
        logic [14:0] temp_address;
        logic [2:0]  fine_x_scroll;
        logic        toggle_out;
        logic [7:0]  control_bits;
        logic [7:0]  mask_bits;
    } t_result;

    // Sprite attribute memory access for one cycle.
    typedef struct packed {
        logic              wr_en;
        logic [SPR_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic [SPR_AW-1:0] rd_addr;
    } t_spr_req;

endpackage

@@ design/vcrp_sprite_ram.sv @@
// Sprite attribute memory of the video chip register port.
// One write port and one registered read port. Uses vcrp_pkg.
module vcrp_sprite_ram (
    input  logic               i_clk,
    input  vcrp_pkg::t_spr_req i_req,
    output logic [7:0]         o_rdata
);

    logic [7:0] r_mem [vcrp_pkg::SPRITE_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rdata <= r_mem[i_req.rd_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/vcrp_regfile.sv @@
// Register-side state of the video chip register port and its update logic.
// Decodes one access, updates the state and forms the result word.
// Uses vcrp_pkg; drives the sprite memory in vcrp_sprite_ram.
module vcrp_regfile (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  vcrp_pkg::t_item    i_item,
    input  logic [7:0]         i_spr_rdata,
    output vcrp_pkg::t_spr_req o_spr_req,
    output vcrp_pkg::t_result  o_result
);

    logic [7:0]  r_bus_latch,   n_bus_latch;
    logic        r_toggle,      n_toggle;
    logic [14:0] r_temp_addr,   n_temp_addr;
    logic [14:0] r_cur_addr,    n_cur_addr;
    logic [2:0]  r_fine_x,      n_fine_x;
    logic [7:0]  r_ctrl,        n_ctrl;
    logic [7:0]  r_mask,        n_mask;
    logic [vcrp_pkg::SPR_AW-1:0] r_sprite_addr, n_sprite_addr;

    logic [7:0] r_palette [vcrp_pkg::PALETTE_ENTRIES];

    logic                        pal_we;
    logic [vcrp_pkg::PAL_AW-1:0] pal_idx;
    logic                        spr_we;
    logic                        req;
    logic [14:0]                 req_addr;
    logic [7:0]                  req_byte;
    logic [7:0]                  wd;

    assign wd = i_item.wdata;

    always_comb begin
        n_bus_latch   = r_bus_latch;
        n_toggle      = r_toggle;
        n_temp_addr   = r_temp_addr;
        n_cur_addr    = r_cur_addr;
        n_fine_x      = r_fine_x;
        n_ctrl        = r_ctrl;
        n_mask        = r_mask;
        n_sprite_addr = r_sprite_addr;
        pal_we        = 1'b0;
        pal_idx       = r_cur_addr[vcrp_pkg::PAL_AW-1:0];
        spr_we        = 1'b0;
        req           = 1'b0;
        req_addr      = '0;
        req_byte      = '0;
        if (i_go) begin
            if (i_item.opcode == vcrp_pkg::OP_READ) begin
                unique case (i_item.reg_sel)
                    vcrp_pkg::REG_STATUS: begin
                        n_bus_latch = {i_item.vblank_flag, i_item.sprite_zero_hit,
                                       i_item.sprite_overflow, r_bus_latch[4:0]};
                        n_toggle    = 1'b0;
                    end
                    vcrp_pkg::REG_OAM_DATA: n_bus_latch = i_spr_rdata;
                    vcrp_pkg::REG_DATA:     n_bus_latch = i_item.buffered_read;
                    default: ;
                endcase
            end else begin
                n_bus_latch = wd;
                unique case (i_item.reg_sel)
                    vcrp_pkg::REG_CTRL: begin
                        n_ctrl             = wd;
                        n_temp_addr[11:10] = wd[1:0];
                    end
                    vcrp_pkg::REG_MASK:     n_mask = wd;
                    vcrp_pkg::REG_OAM_ADDR: n_sprite_addr = wd;
                    vcrp_pkg::REG_OAM_DATA: begin
                        spr_we        = 1'b1;
                        n_sprite_addr = r_sprite_addr + {{(vcrp_pkg::SPR_AW-1){1'b0}}, 1'b1};
                    end
                    vcrp_pkg::REG_SCROLL: begin
                        if (!r_toggle) begin
                            n_fine_x         = wd[2:0];
                            n_temp_addr[4:0] = wd[7:3];
                        end else begin
                            n_temp_addr[14:12] = wd[2:0];
                            n_temp_addr[9:5]   = wd[7:3];
                        end
                        n_toggle = ~r_toggle;
                    end
                    vcrp_pkg::REG_ADDR: begin
                        // The high byte write also clears bit 14.
                        if (!r_toggle) begin
                            n_temp_addr = {1'b0, wd[5:0], r_temp_addr[7:0]};
                        end else begin
                            n_temp_addr = {r_temp_addr[14:8], wd};
                            n_cur_addr  = n_temp_addr;
                        end
                        n_toggle = ~r_toggle;
                    end
                    vcrp_pkg::REG_DATA: begin
                        if (r_cur_addr < vcrp_pkg::PALETTE_BASE) begin
                            req      = 1'b1;
                            req_addr = r_cur_addr;
                            req_byte = wd;
                        end else begin
                            // Backdrop entries of the sprite palettes mirror the
                            // background ones.
                            pal_we = 1'b1;
                            if (r_cur_addr[1:0] == 2'b00) begin
                                pal_idx = {1'b0, r_cur_addr[3:0]};
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_latch   <= '0;
            r_toggle      <= 1'b0;
            r_temp_addr   <= '0;
            r_cur_addr    <= '0;
            r_fine_x      <= '0;
            r_ctrl        <= '0;
            r_mask        <= '0;
            r_sprite_addr <= '0;
        end else begin
            r_bus_latch   <= n_bus_latch;
            r_toggle      <= n_toggle;
            r_temp_addr   <= n_temp_addr;
            r_cur_addr    <= n_cur_addr;
            r_fine_x      <= n_fine_x;
            r_ctrl        <= n_ctrl;
            r_mask        <= n_mask;
            r_sprite_addr <= n_sprite_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_palette[pal_idx] <= wd;
        end
    end

    // The read address follows the next sprite address, so the registered
    // read data always matches the current one. A write never hits the
    // address read in the same cycle, since the address then moves on.
    always_comb begin
        o_spr_req.wr_en   = spr_we;
        o_spr_req.wr_addr = r_sprite_addr;
        o_spr_req.wr_data = wd;
        o_spr_req.rd_addr = n_sprite_addr;
    end

    always_comb begin
        o_result.read_data       = n_bus_latch;
        o_result.vram_write_en   = req;
        o_result.vram_write_addr = req_addr;
        o_result.vram_write_byte = req_byte;
        o_result.temp_address    = n_temp_addr;
        o_result.fine_x_scroll   = n_fine_x;
        o_result.toggle_out      = n_toggle;
        o_result.control_bits    = n_ctrl;
        o_result.mask_bits       = n_mask;
    end

endmodule

@@ design/video_chip_register_port_unit.sv @@
// Video chip register port: an input register, the register-side state with
// its decode logic, and a result register. Uses vcrp_pkg, vcrp_regfile and
// vcrp_sprite_ram.
//
// Takes one CPU access to the eight-register window per word and returns one
// result word per access. A new word is taken in every cycle while results
// are taken; a word is held in the input register and appears at the output
// when it moves into the result register. The state update and the sprite
// memory read both happen in the decode step between the two registers.
// o_in_stall rises only while a result waits and the output is stalled.
// Palette memory and sprite memory hold no defined contents until written.
module video_chip_register_port_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [2:0]  i_reg_sel,
    input  logic [7:0]  i_wdata,
    input  logic        i_vblank_flag,
    input  logic        i_sprite_zero_hit,
    input  logic        i_sprite_overflow,
    input  logic [7:0]  i_buffered_read,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,
    output logic        o_vram_write_en,
    output logic [14:0] o_vram_write_addr,
    output logic [7:0]  o_vram_write_byte,
    output logic [14:0] o_temp_address,
    output logic [2:0]  o_fine_x_scroll,
    output logic        o_toggle_out,
    output logic [7:0]  o_control_bits,
    output logic [7:0]  o_mask_bits
);

    logic              r_in_valid;
    vcrp_pkg::t_item   r_in;
    logic              r_out_valid;
    vcrp_pkg::t_result r_out;

    logic               adv;
    logic               accept;
    vcrp_pkg::t_result  result;
    vcrp_pkg::t_spr_req spr_req;
    logic [7:0]         spr_rdata;

    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.opcode          <= i_opcode;
            r_in.reg_sel         <= i_reg_sel;
            r_in.wdata           <= i_wdata;
            r_in.vblank_flag     <= i_vblank_flag;
            r_in.sprite_zero_hit <= i_sprite_zero_hit;
            r_in.sprite_overflow <= i_sprite_overflow;
            r_in.buffered_read   <= i_buffered_read;
        end
        if (adv) begin
            r_out <= result;
        end
    end

    vcrp_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (adv),
        .i_item      (r_in),
        .i_spr_rdata (spr_rdata),
        .o_spr_req   (spr_req),
        .o_result    (result)
    );

    vcrp_sprite_ram u_sprite_ram (
        .i_clk   (i_clk),
        .i_req   (spr_req),
        .o_rdata (spr_rdata)
    );

    assign o_out_valid       = r_out_valid;
    assign o_read_data       = r_out.read_data;
    assign o_vram_write_en   = r_out.vram_write_en;
    assign o_vram_write_addr = r_out.vram_write_addr;
    assign o_vram_write_byte = r_out.vram_write_byte;
    assign o_temp_address    = r_out.temp_address;
    assign o_fine_x_scroll   = r_out.fine_x_scroll;
    assign o_toggle_out      = r_out.toggle_out;
    assign o_control_bits    = r_out.control_bits;
    assign o_mask_bits       = r_out.mask_bits;

endmodule

@@ design/vcrp_checker.sv @@
// Port-level checks for the video chip register port.
// Watches only the top level's ports; bound to video_chip_register_port_unit.
module vcrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_read_data,
    input logic        o_vram_write_en,
    input logic [14:0] o_vram_write_addr,
    input logic [7:0]  o_vram_write_byte,
    input logic [14:0] o_temp_address
);

    // The input side only backs up when a result is held at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && i_out_stall) |-> !o_in_stall)
        else $error("input stalled while the output was free");

    a_req_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_vram_write_en |-> o_vram_write_addr < 15'h3F00)
        else $error("video memory write request in the palette range");

    // A data write leaves its byte on the bus latch as well.
    a_req_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_vram_write_en |-> o_read_data == o_vram_write_byte)
        else $error("bus latch differs from the requested write byte");

    a_no_req_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_vram_write_en |->
            o_vram_write_addr == 15'd0 && o_vram_write_byte == 8'd0)
        else $error("request fields not zero without a request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_read_data) && $stable(o_temp_address))
        else $error("stalled result word changed");

endmodule

bind video_chip_register_port_unit vcrp_checker u_vcrp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_read_data       (o_read_data),
    .o_vram_write_en   (o_vram_write_en),
    .o_vram_write_addr (o_vram_write_addr),
    .o_vram_write_byte (o_vram_write_byte),
    .o_temp_address    (o_temp_address)
);
